/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define KPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define KPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/kpc_pkg.sv */
package kpc_pkg;

  localparam int ROWS_DEF   = 4;
  localparam int COLS_DEF   = 3;
  localparam int MATRIX_W   = 12;
  localparam int TIME_W     = 16;
  localparam int KEY_W      = 4;
  localparam int EV_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [KEY_W-1:0] NO_KEY = 4'd15;

  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_CLICK = 2'd1;
  localparam logic [EV_W-1:0] EV_LONG  = 2'd2;
  localparam logic [EV_W-1:0] EV_HOLD  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_LONG   = 2'd2;

  localparam logic [TIME_W-1:0] LONG_PRESS_RST  = 16'd1500;
  localparam logic [TIME_W-1:0] SHORT_PRESS_RST = 16'd50;

  typedef struct packed {
    logic [MATRIX_W-1:0] pressed_matrix;
    logic                encoder_pressed;
    logic [TIME_W-1:0]   now_ms;
  } in_word_t;

  typedef struct packed {
    logic [EV_W-1:0]  press_event;
    logic [KEY_W-1:0] key_code;
  } out_word_t;

endpackage

/* rtl/core/keypad_press_classifier.sv */
// Result: an accepted word's classification is registered in out_r, or in skid_r while out stalls.
// Throughput: one word per cycle while in_stall is low; the classification is a single registered pass.
// Result plus skid register: one more word is taken while out stalls, then in_stall.
// Reset (synchronous, rst_n low): no key held, anchor 0, flags clear, outputs empty,
// registers back to long 1500 ms, short 50 ms, auto long press on.
module keypad_press_classifier #(
  parameter int ROWS = kpc_pkg::ROWS_DEF,
  parameter int COLS = kpc_pkg::COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  kpc_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output kpc_pkg::out_word_t             out_word,
  input  logic                           cfg_we,
  input  logic [kpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [kpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NKEYS = ROWS * COLS;
  localparam logic [kpc_pkg::KEY_W-1:0] ENC_KEY = kpc_pkg::KEY_W'(NKEYS);

  logic [kpc_pkg::TIME_W-1:0] long_ms_r, short_ms_r;
  logic                       auto_long_r;

  logic [kpc_pkg::KEY_W-1:0]  prev_key_r, prev_key_nxt;
  logic [kpc_pkg::TIME_W-1:0] anchor_r, anchor_nxt;
  logic                       ev_rep_r, ev_rep_nxt;
  logic                       hold_rep_r, hold_rep_nxt;

  kpc_pkg::out_word_t out_r, skid_r, res;
  logic               out_valid_r, skid_valid_r;

  logic                       acc_in;
  logic [kpc_pkg::KEY_W-1:0]  key;
  logic [kpc_pkg::TIME_W-1:0] elapsed;
  logic [kpc_pkg::TIME_W:0]   hold_thr;

  assign acc_in    = in_valid & ~skid_valid_r;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ms_r   <= kpc_pkg::LONG_PRESS_RST;
      short_ms_r  <= kpc_pkg::SHORT_PRESS_RST;
      auto_long_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        kpc_pkg::REG_LONG_PRESS:  long_ms_r   <= cfg_wdata;
        kpc_pkg::REG_SHORT_PRESS: short_ms_r  <= cfg_wdata;
        kpc_pkg::REG_AUTO_LONG:   auto_long_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // key priority: encoder, then first row, then highest column in it
  always_comb begin
    key = kpc_pkg::NO_KEY;
    for (int r = ROWS - 1; r >= 0; r--) begin
      for (int c = 0; c < COLS; c++) begin
        if (in_word.pressed_matrix[r * COLS + c]) begin
          key = kpc_pkg::KEY_W'(r * COLS + c);
        end
      end
    end
    if (in_word.encoder_pressed) begin
      key = ENC_KEY;
    end
  end

  assign elapsed  = in_word.now_ms - anchor_r;
  assign hold_thr = {1'b0, short_ms_r} + 17'd1;

  always_comb begin
    prev_key_nxt = prev_key_r;
    anchor_nxt   = anchor_r;
    ev_rep_nxt   = ev_rep_r;
    hold_rep_nxt = hold_rep_r;
    res.press_event = kpc_pkg::EV_NONE;
    res.key_code    = kpc_pkg::NO_KEY;
    if (prev_key_r != key) begin
      if (prev_key_r == kpc_pkg::NO_KEY) begin
        ev_rep_nxt   = 1'b0;
        hold_rep_nxt = 1'b0;
        anchor_nxt   = in_word.now_ms;
      end else if (key == kpc_pkg::NO_KEY && !ev_rep_r) begin
        if (elapsed < long_ms_r && elapsed > short_ms_r) begin
          ev_rep_nxt      = 1'b1;
          res.press_event = kpc_pkg::EV_CLICK;
          res.key_code    = prev_key_r;
        end else if (elapsed > long_ms_r) begin
          ev_rep_nxt      = 1'b1;
          res.press_event = kpc_pkg::EV_LONG;
          res.key_code    = prev_key_r;
        end
      end
      prev_key_nxt = key;
    end else if (key != kpc_pkg::NO_KEY) begin
      if (!ev_rep_r && auto_long_r && elapsed >= long_ms_r) begin
        ev_rep_nxt      = 1'b1;
        res.press_event = kpc_pkg::EV_LONG;
        res.key_code    = prev_key_r;
      end
      if (!hold_rep_r && {1'b0, elapsed} > hold_thr) begin
        hold_rep_nxt    = 1'b1;
        res.press_event = kpc_pkg::EV_HOLD;
        res.key_code    = prev_key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_key_r <= kpc_pkg::NO_KEY;
      anchor_r   <= '0;
      ev_rep_r   <= 1'b0;
      hold_rep_r <= 1'b0;
    end else if (acc_in) begin
      prev_key_r <= prev_key_nxt;
      anchor_r   <= anchor_nxt;
      ev_rep_r   <= ev_rep_nxt;
      hold_rep_r <= hold_rep_nxt;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r  <= skid_valid_r | acc_in;
      skid_valid_r <= 1'b0;
    end else if (acc_in) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (acc_in) begin
      skid_r <= res;
    end
  end

endmodule

/* rtl/core/kpc_checker.sv */
`include "assert_macros.svh"

module kpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input kpc_pkg::out_word_t out_word
);

  logic out_wait, in_block, no_event, no_code;

  assign out_wait = out_valid && out_stall;
  assign in_block = out_wait && in_valid;
  assign no_event = (out_word.press_event == kpc_pkg::EV_NONE);
  assign no_code  = (out_word.key_code == kpc_pkg::NO_KEY);

  `KPC_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(out_word), "stalled word changed")
  `KPC_ASSERT(a_no_event_code, out_valid |-> (no_event == no_code), "code disagrees with event")
  `KPC_ASSERT(a_stall_cause, $rose(in_stall) |-> $past(in_block), "stall with no cause")
  `KPC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "not empty after reset")

endmodule

bind keypad_press_classifier kpc_checker u_kpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
